// ===== hw/rtl/ppd_pkg.sv =====
// Shared widths, register codes and the lane output type for the pair distance core.
package ppd_pkg;

   localparam int CW      = 20;            // coordinate / box / distance width
   localparam int DW      = CW + 1;        // signed difference, its magnitude
   localparam int SQW     = 2 * CW;        // one squared axis term
   localparam int SUMW    = 2 * CW + 2;    // sum of three squares
   localparam int RW      = SUMW / 2;      // raw root width
   localparam int REMW    = RW + 3;        // square root partial remainder
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam int LANE_LAT  = DW + 2;      // magnitude, remainder steps, square
   localparam int MERGE_LAT = RW + 1;      // sum, root steps
   localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

   localparam logic [CW-1:0] BOX_RESET = CW'(25600);
   localparam logic [CW-1:0] DIST_MAX  = {CW{1'b1}};

   typedef enum logic [1:0] {
      REG_BOX_X = 2'd0,
      REG_BOX_Y = 2'd1,
      REG_BOX_Z = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [SQW-1:0] sq;
      logic           sat;
   } lane_out_type;

endpackage

// ===== hw/rtl/ppd_if.sv =====
// Valid/ready channel interfaces for request and response items.
interface ppd_req_if;
   import ppd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] first_x;
   logic signed [CW-1:0] first_y;
   logic signed [CW-1:0] first_z;
   logic signed [CW-1:0] second_x;
   logic signed [CW-1:0] second_y;
   logic signed [CW-1:0] second_z;

   modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   input ready);
   modport sink   (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   output ready);
endinterface

interface ppd_rsp_if;
   import ppd_pkg::*;
   logic          valid;
   logic          ready;
   logic [CW-1:0] distance;

   modport source (output valid, distance, input ready);
   modport sink   (input valid, distance, output ready);
endinterface

// ===== hw/rtl/ppd_lane.sv =====
// One axis lane: difference, periodic fold by pipelined remainder, square.
module ppd_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [ppd_pkg::CW-1:0] first,
   input  logic signed [ppd_pkg::CW-1:0] second,
   input  logic [ppd_pkg::CW-1:0]        box_len,
   output ppd_pkg::lane_out_type         lane_out
);
   import ppd_pkg::*;

   logic signed [DW-1:0] diff;
   logic [DW-1:0]        mag_in;
   logic [DW-1:0]        rem_ff [DW+1];
   logic [DW-1:0]        r;
   logic [DW-1:0]        len_ext;
   logic [DW-1:0]        fold_in;
   lane_out_type         out_in;
   lane_out_type         out_ff;

   assign diff    = $signed({second[CW-1], second}) - $signed({first[CW-1], first});
   assign mag_in  = diff[DW-1] ? DW'(-diff) : DW'(diff);
   assign len_ext = DW'(box_len);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= mag_in;
      end
   end

   // one restoring remainder step per stage, most significant quotient bit first
   for (genvar s = 0; s < DW; s++) begin : g_rem
      localparam int K = DW - 1 - s;
      logic [DW-1:0] step_in;
      always_comb begin
         if ((rem_ff[s] >> K) >= len_ext) begin
            step_in = rem_ff[s] - DW'(len_ext << K);
         end else begin
            step_in = rem_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= step_in;
         end
      end
   end

   assign r = rem_ff[DW];

   // nearest image: min(r, len - r); zero length leaves the axis unfolded
   always_comb begin
      if (box_len == '0) begin
         fold_in = r;
      end else if ({r, 1'b0} > {1'b0, len_ext}) begin
         fold_in = len_ext - r;
      end else begin
         fold_in = r;
      end
      out_in.sat = fold_in[DW-1];
      out_in.sq  = fold_in[CW-1:0] * fold_in[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign lane_out = out_ff;

endmodule

// ===== hw/rtl/ppd_merge.sv =====
// Merge stage: sum of the lane squares and pipelined integer square root.
module ppd_merge (
   input  logic                   clock,
   input  logic                   en,
   input  ppd_pkg::lane_out_type  lane_x,
   input  ppd_pkg::lane_out_type  lane_y,
   input  ppd_pkg::lane_out_type  lane_z,
   output logic [ppd_pkg::CW-1:0] distance
);
   import ppd_pkg::*;

   logic [SUMW-1:0] n_ff    [RW+1];
   logic [REMW-1:0] rem_ff  [RW+1];
   logic [RW-1:0]   root_ff [RW+1];
   logic            sat_ff  [RW+1];

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0]    <= SUMW'(lane_x.sq) + SUMW'(lane_y.sq) + SUMW'(lane_z.sq);
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         sat_ff[0]  <= lane_x.sat | lane_y.sat | lane_z.sat;
      end
   end

   // digit-by-digit root, two radicand bits per stage
   for (genvar j = 0; j < RW; j++) begin : g_root
      logic [REMW-1:0] remx;
      logic [REMW-1:0] trial;
      logic [REMW-1:0] rem_in;
      logic [RW-1:0]   root_in;
      always_comb begin
         remx  = {rem_ff[j][REMW-3:0], n_ff[j][SUMW-1 -: 2]};
         trial = REMW'({root_ff[j], 2'b01});
         if (remx >= trial) begin
            rem_in  = remx - trial;
            root_in = {root_ff[j][RW-2:0], 1'b1};
         end else begin
            rem_in  = remx;
            root_in = {root_ff[j][RW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[j+1]    <= n_ff[j] << 2;
            rem_ff[j+1]  <= rem_in;
            root_ff[j+1] <= root_in;
            sat_ff[j+1]  <= sat_ff[j];
         end
      end
   end

   assign distance = (sat_ff[RW] || root_ff[RW][RW-1]) ? DIST_MAX : root_ff[RW][CW-1:0];

endmodule

// ===== hw/rtl/periodic_pair_distance_core.sv =====
// Top level: minimum-image distance core with APB box registers.
//
//  channel   dir  handshake          payload
//  req_chan  in   valid/ready        first_x/y/z, second_x/y/z (signed Q12.8)
//  rsp_chan  out  valid/ready        distance (unsigned Q12.8)
//  apb       in   psel/penable       box_len_x/y/z at 0x0/0x4/0x8
//
// One item per cycle while the output is not stalled. An item passes the axis
// lanes (magnitude, 21 remainder steps, square), then the merge (sum, 21 root
// steps), then the output register before rsp valid.
// Whole pipeline advances when the output register is empty or being taken;
// req ready follows that same enable.
// Synchronous active-high reset clears valids and sets each box to 100.0.
module periodic_pair_distance_core (
   input  logic                           clock,
   input  logic                           reset,
   ppd_req_if.sink                        req_chan,
   ppd_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ppd_pkg::ADDR_W-1:0]     paddr,
   input  logic [ppd_pkg::DATA_W-1:0]     pwdata,
   output logic [ppd_pkg::DATA_W-1:0]     prdata,
   output logic                           pready
);
   import ppd_pkg::*;

   logic [CW-1:0]       box_x_ff, box_x_in;
   logic [CW-1:0]       box_y_ff, box_y_in;
   logic [CW-1:0]       box_z_ff, box_z_in;
   reg_idx_type         reg_idx;
   logic                wr_en;

   logic                en;
   logic [PIPE_LAT-1:0] vld_ff, vld_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]       rsp_dist_ff;
   logic [CW-1:0]       merge_dist;
   lane_out_type        lane_x, lane_y, lane_z;

   // ---- configuration registers ----
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = reg_idx_type'(paddr[3:2]);

   always_comb begin
      box_x_in = box_x_ff;
      box_y_in = box_y_ff;
      box_z_in = box_z_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_BOX_X: box_x_in = pwdata[CW-1:0];
            REG_BOX_Y: box_y_in = pwdata[CW-1:0];
            REG_BOX_Z: box_z_in = pwdata[CW-1:0];
            default: ;                         // unmapped: ignored
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BOX_X: prdata = DATA_W'(box_x_ff);
         REG_BOX_Y: prdata = DATA_W'(box_y_ff);
         REG_BOX_Z: prdata = DATA_W'(box_z_ff);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= BOX_RESET;
         box_y_ff <= BOX_RESET;
         box_z_ff <= BOX_RESET;
      end else begin
         box_x_ff <= box_x_in;
         box_y_ff <= box_y_in;
         box_z_ff <= box_z_in;
      end
   end

   // ---- flow control: stall only when a finished item sits untaken ----
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   assign vld_in       = en ? {vld_ff[PIPE_LAT-2:0], req_chan.valid} : vld_ff;
   assign rsp_valid_in = en ? vld_ff[PIPE_LAT-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- three axis lanes ----
   ppd_lane u_lane_x (
      .clock    (clock),
      .en       (en),
      .first    (req_chan.first_x),
      .second   (req_chan.second_x),
      .box_len  (box_x_ff),
      .lane_out (lane_x)
   );

   ppd_lane u_lane_y (
      .clock    (clock),
      .en       (en),
      .first    (req_chan.first_y),
      .second   (req_chan.second_y),
      .box_len  (box_y_ff),
      .lane_out (lane_y)
   );

   ppd_lane u_lane_z (
      .clock    (clock),
      .en       (en),
      .first    (req_chan.first_z),
      .second   (req_chan.second_z),
      .box_len  (box_z_ff),
      .lane_out (lane_z)
   );

   // ---- sum and root ----
   ppd_merge u_merge (
      .clock    (clock),
      .en       (en),
      .lane_x   (lane_x),
      .lane_y   (lane_y),
      .lane_z   (lane_z),
      .distance (merge_dist)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_dist_ff <= merge_dist;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.distance = rsp_dist_ff;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the minimum-image pair distance core.
module tb_top;
   import ppd_pkg::*;

   localparam int LIMIT = 5000;   // idle cycles before the watchdog fires
   localparam int DRAIN = 60;     // pipeline latency plus margin

   // Scoreboard: predicted distances held in arrival order.
   class dist_board;
      logic [CW-1:0] box[3];
      logic [CW-1:0] dist_q[$];
      int            errs;

      function new();
         box[0] = BOX_RESET; box[1] = BOX_RESET; box[2] = BOX_RESET;
         errs = 0;
      endfunction

      // Folded magnitude of one axis difference; round half away from zero.
      function automatic longint unsigned fold(longint d, logic [CW-1:0] len);
         longint unsigned a, q, l;
         longint r;
         a = (d < 0) ? -d : d;
         l = len;
         if (l == 0) return a;
         q = (2 * a + l) / (2 * l);
         r = longint'(a) - longint'(q * l);
         return (r < 0) ? -r : r;
      endfunction

      function automatic longint unsigned isqrt(longint unsigned n);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv >>= 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      function void note_pair(logic signed [CW-1:0] f[3], logic signed [CW-1:0] s[3]);
         longint unsigned m, total, root;
         total = 0;
         for (int k = 0; k < 3; k++) begin
            m = fold(longint'(s[k]) - longint'(f[k]), box[k]);
            if (m > DIST_MAX) m = DIST_MAX + 1;   // forces saturation below
            total += m * m;
         end
         root = isqrt(total);
         if (root > DIST_MAX) root = DIST_MAX;
         dist_q.push_back(root[CW-1:0]);
      endfunction

      function void check_dist(logic [CW-1:0] got);
         logic [CW-1:0] want;
         if (dist_q.size() == 0) begin
            errs++;
            if (errs <= 10) $display("unexpected distance %0d", got);
            return;
         end
         want = dist_q.pop_front();
         if (got !== want) begin
            errs++;
            if (errs <= 10) $display("distance: expected %0d got %0d", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   ppd_req_if req_chan ();
   ppd_rsp_if rsp_chan ();

   periodic_pair_distance_core i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   dist_board board = new();
   int send_idle = 0;   // percent
   int recv_stall = 0;  // percent
   int quiet = 0;

   initial begin
      req_chan.valid = 0;
      req_chan.first_x = '0; req_chan.first_y = '0; req_chan.first_z = '0;
      req_chan.second_x = '0; req_chan.second_y = '0; req_chan.second_z = '0;
      rsp_chan.ready = 0;
   end

   // Receiver: random stalls, checks every taken item.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) board.check_dist(rsp_chan.distance);
      rsp_chan.ready <= !reset && ($urandom_range(99) >= recv_stall);
   end

   // Watchdog on cycles with no accepted item on either channel.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || reset)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic write_box(reg_idx_type idx, logic [CW-1:0] val);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= ADDR_W'(4 * int'(idx)); pwdata <= DATA_W'(val);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.box[idx] = val;
      psel <= 0; penable <= 0; pwrite <= 0;
      @(posedge clock);
   endtask

   // Wait for all results, then let the pipeline drain.
   task automatic settle();
      while (board.dist_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic send_pair(logic signed [CW-1:0] f[3], logic signed [CW-1:0] s[3]);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.first_x <= f[0]; req_chan.first_y <= f[1]; req_chan.first_z <= f[2];
      req_chan.second_x <= s[0]; req_chan.second_y <= s[1]; req_chan.second_z <= s[2];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_pair(f, s);
   endtask

   function automatic logic signed [CW-1:0] rnd_coord();
      case ($urandom_range(3))
         0: return CW'($urandom);
         1: return CW'($urandom_range(4000)) - CW'(2000);
         2: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
         default: return CW'($urandom_range(60000)) - CW'(30000);
      endcase
   endfunction

   function automatic logic [CW-1:0] rnd_box();
      case ($urandom_range(4))
         0: return '0;
         1: return DIST_MAX;
         2: return CW'($urandom);
         default: return CW'($urandom_range(50000, 1));
      endcase
   endfunction

   // Random pairs in one idling phase.
   task automatic random_phase(int n, int idle, int stall);
      logic signed [CW-1:0] f[3], s[3];
      send_idle = idle; recv_stall = stall;
      for (int i = 0; i < n; i++) begin
         for (int k = 0; k < 3; k++) begin
            f[k] = rnd_coord();
            s[k] = $urandom_range(1) ? rnd_coord() : f[k] + CW'($urandom_range(512)) - CW'(256);
         end
         send_pair(f, s);
      end
      req_chan.valid <= 0;
      @(posedge clock);
   endtask

   initial begin
      logic signed [CW-1:0] f[3], s[3];
      logic signed [CW-1:0] mx, mn;
      mx = {1'b0, {(CW-1){1'b1}}};
      mn = {1'b1, {(CW-1){1'b0}}};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reset boxes, zero, extremes, exact halves, then zero boxes and boxes of max, 1 and 2.
      f = '{0, 0, 0}; s = '{0, 0, 0}; send_pair(f, s);
      f = '{mn, mn, mn}; s = '{mx, mx, mx}; send_pair(f, s);
      f = '{mx, mx, mx}; s = '{mn, mn, mn}; send_pair(f, s);
      f = '{0, 0, 0}; s = '{12800, -12800, 25600}; send_pair(f, s);
      f = '{100, 0, 0}; s = '{12801, 0, -12801}; send_pair(f, s);
      f = '{0, 0, 0}; s = '{-1, 1, 12799}; send_pair(f, s);
      req_chan.valid <= 0;
      settle();
      write_box(REG_BOX_X, '0);
      write_box(REG_BOX_Y, '0);
      write_box(REG_BOX_Z, '0);
      f = '{mn, mn, mn}; s = '{mx, mx, mx}; send_pair(f, s);
      f = '{mx, 0, mn}; s = '{mn, 0, mx}; send_pair(f, s);
      f = '{0, 0, 0}; s = '{-5, 3, 7}; send_pair(f, s);
      req_chan.valid <= 0;
      settle();
      write_box(REG_BOX_X, DIST_MAX);
      write_box(REG_BOX_Y, 1);
      write_box(REG_BOX_Z, 2);
      f = '{mn, 0, 0}; s = '{mx, 1, 1}; send_pair(f, s);
      f = '{0, 0, 0}; s = '{mx, -1, 3}; send_pair(f, s);
      f = '{mx, mn, mx}; s = '{mn, mx, mn}; send_pair(f, s);
      req_chan.valid <= 0;
      settle();

      // Random phases, new boxes between them.
      for (int p = 0; p < 8; p++) begin
         write_box(REG_BOX_X, rnd_box());
         write_box(REG_BOX_Y, rnd_box());
         write_box(REG_BOX_Z, rnd_box());
         case (p % 4)
            0: random_phase(145, 0, 0);
            1: random_phase(145, 47, 0);
            2: random_phase(145, 0, 47);
            default: random_phase(145, 11, 11);
         endcase
         settle();
      end

      if (board.errs == 0 && board.dist_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

// ===== periodic_pair_distance_core.f =====
hw/rtl/ppd_pkg.sv
hw/rtl/ppd_if.sv
hw/rtl/ppd_lane.sv
hw/rtl/ppd_merge.sv
hw/rtl/periodic_pair_distance_core.sv
bench/tb_top.sv
